@@ design/cstc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstc_pkg
// shared types and constants of the character stream token classifier
// ----------------------------------------------------------------------------
package cstc_pkg;

    localparam int DEFAULT_MAX_TOKEN_LEN = 255;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_EOF   = 8'hFF;

    typedef enum logic [3:0] {
        KIND_NIL    = 4'd0,
        KIND_END    = 4'd1,
        KIND_KW_FLT = 4'd2,
        KIND_KW_INT = 4'd3,
        KIND_PRINT  = 4'd4,
        KIND_ASSIGN = 4'd5,
        KIND_PLUS   = 4'd6,
        KIND_MINUS  = 4'd7,
        KIND_ID     = 4'd8,
        KIND_INT    = 4'd9,
        KIND_FLOAT  = 4'd10
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } byte_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] token_start;
        logic [7:0]  token_length;
        logic        length_overflow;
        logic        last_of_run;
    } token_t;

endpackage

@@ design/char_stream_token_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_stream_token_classifier
// splits a byte stream into tokens and reports kind, start offset and length
// ----------------------------------------------------------------------------
//  channel   | dir | payload  | handshake
//  byte      | in  | byte_t   | byte_valid / byte_stall
//  token     | out | token_t  | token_valid / token_stall
//
//  one byte per cycle while byte_stall is low; pattern state updates in the cycle the byte is taken
//  each byte yields zero to two tokens, queued in a four-entry token fifo
//  byte_stall rises when the fifo has fewer than two free entries
//  token output drains one transaction per cycle, while token_stall is low, from the fifo head
//  rst_n clears the stream position, pending token state and the fifo
// ----------------------------------------------------------------------------
module char_stream_token_classifier
    import cstc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEFAULT_MAX_TOKEN_LEN
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   byte_valid,
    output logic   byte_stall,
    input  byte_t  byte_data,
    output logic   token_valid,
    input  logic   token_stall,
    output token_t token_data
);

    localparam int LEN_W      = $clog2(MAX_TOKEN_LEN + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        KW_START, KW_F, KW_FL, KW_FLO, KW_FLOA, KW_FLOAT,
        KW_I, KW_IN, KW_INT, KW_P, KW_PR, KW_PRI, KW_PRIN, KW_PRINT, KW_DEAD
    } kw_state_t;

    typedef enum logic [1:0] {
        FLT_NONE, FLT_INT, FLT_DOT, FLT_FRAC
    } flt_state_t;

    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      start_reg, start_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    kw_state_t        kw_reg, kw_next;
    logic             int_ok_reg, int_ok_next;
    logic             id_ok_reg, id_ok_next;
    flt_state_t       flt_reg, flt_next;

    token_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    token_t           res0, res1;
    token_t           flush_tok, end_tok, op_tok;
    kind_t            flush_kind;
    logic             pending;
    logic             is_end, is_nul, is_sep, is_op;
    logic             is_dig, is_idc;
    logic [7:0]       c;
    logic [LEN_W+7:0] len_ext;

    assign accept      = byte_valid && !byte_stall;
    assign pop         = token_valid && !token_stall;
    assign byte_stall  = count_reg > CNT_W'(FIFO_DEPTH - 2);
    assign token_valid = count_reg != '0;
    assign token_data  = fifo_reg[rd_ptr_reg];

    assign c       = byte_data.ch;
    assign is_end  = byte_data.end_of_input || c == CH_EOF;
    assign is_nul  = !byte_data.end_of_input && c == CH_NUL;
    assign is_sep  = c == CH_SPACE || c == CH_LF;
    assign is_op   = c == CH_EQ || c == CH_PLUS || c == CH_MINUS;
    assign is_dig  = c >= "0" && c <= "9";
    assign is_idc  = is_dig || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign pending = len_reg != '0;
    assign len_ext = {8'd0, len_reg};

    always_comb
    begin
        if (kw_reg == KW_FLOAT)
            flush_kind = KIND_KW_FLT;
        else if (kw_reg == KW_INT)
            flush_kind = KIND_KW_INT;
        else if (kw_reg == KW_PRINT)
            flush_kind = KIND_PRINT;
        else if (int_ok_reg)
            flush_kind = KIND_INT;
        else if (id_ok_reg)
            flush_kind = KIND_ID;
        else if (flt_reg == FLT_FRAC)
            flush_kind = KIND_FLOAT;
        else
            flush_kind = KIND_NIL;
    end

    always_comb
    begin
        flush_tok.token_kind      = flush_kind;
        flush_tok.token_start     = start_reg;
        flush_tok.token_length    = len_ext[7:0];
        flush_tok.length_overflow = ovf_reg;
        flush_tok.last_of_run     = 1'b0;

        end_tok.token_kind      = KIND_END;
        end_tok.token_start     = pos_reg;
        end_tok.token_length    = 8'd0;
        end_tok.length_overflow = 1'b0;
        end_tok.last_of_run     = 1'b1;

        op_tok.token_kind      = (c == CH_EQ) ? KIND_ASSIGN :
                                 (c == CH_PLUS) ? KIND_PLUS : KIND_MINUS;
        op_tok.token_start     = pos_reg;
        op_tok.token_length    = 8'd1;
        op_tok.length_overflow = 1'b0;
        op_tok.last_of_run     = 1'b1;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        kw_next     = kw_reg;
        int_ok_next = int_ok_reg;
        id_ok_next  = id_ok_reg;
        flt_next    = flt_reg;
        push_n      = 2'd0;
        res0        = end_tok;
        res1        = end_tok;

        if (accept)
        begin
            if (is_end || is_nul || is_sep || is_op)
            begin
                // flush or drop pending token
                len_next    = '0;
                ovf_next    = 1'b0;
                kw_next     = KW_START;
                int_ok_next = 1'b1;
                id_ok_next  = 1'b1;
                flt_next    = FLT_NONE;
                start_next  = '0;
            end

            if (is_end || is_nul)
            begin
                pos_next = '0;
                if (is_end && pending)
                begin
                    res0   = flush_tok;
                    res1   = end_tok;
                    push_n = 2'd2;
                end
                else
                begin
                    res0   = end_tok;
                    push_n = 2'd1;
                end
            end
            else if (is_sep)
            begin
                pos_next = pos_reg + 32'd1;
                res0     = flush_tok;
                res0.last_of_run = 1'b1;
                push_n   = pending ? 2'd1 : 2'd0;
            end
            else if (is_op)
            begin
                pos_next = pos_reg + 32'd1;
                if (pending)
                begin
                    res0   = flush_tok;
                    res1   = op_tok;
                    push_n = 2'd2;
                end
                else
                begin
                    res0   = op_tok;
                    push_n = 2'd1;
                end
            end
            else
            begin
                pos_next = pos_reg + 32'd1;
                if (!pending)
                begin
                    start_next  = pos_reg;
                    int_ok_next = c >= "1" && c <= "9";
                    flt_next    = is_dig ? FLT_INT : FLT_NONE;
                end
                else
                begin
                    int_ok_next = int_ok_reg && is_dig;
                    case (flt_reg)
                        FLT_INT:  flt_next = is_dig ? FLT_INT : ((c == ".") ? FLT_DOT : FLT_NONE);
                        FLT_DOT:  flt_next = is_dig ? FLT_FRAC : FLT_NONE;
                        FLT_FRAC: flt_next = is_dig ? FLT_FRAC : FLT_NONE;
                        default:  flt_next = FLT_NONE;
                    endcase
                end
                id_ok_next = id_ok_reg && is_idc;

                case (kw_reg)
                    KW_START: kw_next = (c == "f") ? KW_F :
                                        (c == "i") ? KW_I :
                                        (c == "p") ? KW_P : KW_DEAD;
                    KW_F:     kw_next = (c == "l") ? KW_FL   : KW_DEAD;
                    KW_FL:    kw_next = (c == "o") ? KW_FLO  : KW_DEAD;
                    KW_FLO:   kw_next = (c == "a") ? KW_FLOA : KW_DEAD;
                    KW_FLOA:  kw_next = (c == "t") ? KW_FLOAT : KW_DEAD;
                    KW_I:     kw_next = (c == "n") ? KW_IN   : KW_DEAD;
                    KW_IN:    kw_next = (c == "t") ? KW_INT  : KW_DEAD;
                    KW_P:     kw_next = (c == "r") ? KW_PR   : KW_DEAD;
                    KW_PR:    kw_next = (c == "i") ? KW_PRI  : KW_DEAD;
                    KW_PRI:   kw_next = (c == "n") ? KW_PRIN : KW_DEAD;
                    KW_PRIN:  kw_next = (c == "t") ? KW_PRINT : KW_DEAD;
                    default:  kw_next = KW_DEAD;
                endcase

                if (len_reg >= LEN_W'(MAX_TOKEN_LEN))
                    ovf_next = 1'b1;
                else
                    len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            kw_reg     <= KW_START;
            int_ok_reg <= 1'b1;
            id_ok_reg  <= 1'b1;
            flt_reg    <= FLT_NONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            kw_reg     <= kw_next;
            int_ok_reg <= int_ok_next;
            id_ok_reg  <= id_ok_next;
            flt_reg    <= flt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

endmodule

@@ design/cstc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstc_checker
// port level checks of the token classifier, bound to the top level
// ----------------------------------------------------------------------------
module cstc_checker
    import cstc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEFAULT_MAX_TOKEN_LEN
)
(
    input logic   clk,
    input logic   rst_n,
    input logic   byte_stall,
    input logic   token_valid,
    input logic   token_stall,
    input token_t token_data
);

    localparam logic [7:0] MAX_LEN_LOW = 8'(MAX_TOKEN_LEN & 255);

    // stalled token transaction holds
    a_token_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_data))
        else $error("token payload changed under stall");

    // input only stalls while tokens are waiting
    a_stall_room: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> token_valid)
        else $error("byte stall with no token waiting");

    // end of stream is always the final, empty token of its run
    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_data.token_kind == KIND_END |->
            token_data.last_of_run && token_data.token_length == 8'd0 &&
            !token_data.length_overflow)
        else $error("malformed end token");

    // operators are one byte and close their run
    a_op_shape: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_data.token_kind == KIND_ASSIGN ||
                        token_data.token_kind == KIND_PLUS ||
                        token_data.token_kind == KIND_MINUS) |->
            token_data.last_of_run && token_data.token_length == 8'd1 &&
            !token_data.length_overflow)
        else $error("malformed operator token");

    // overflow only at the saturated length
    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_data.length_overflow |->
            token_data.token_length == MAX_LEN_LOW)
        else $error("overflow without saturated length");

endmodule

bind char_stream_token_classifier cstc_checker #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_cstc_checker (.*);

@@ bench/char_stream_token_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_stream_token_classifier_tb
// self-checking bench for the character stream token classifier
//
// a short table of directed bytes (reset, stream end, operators, keywords,
// float, dropped token) is followed by three random phases of word-shaped
// byte streams with noise, overlong tokens and stream ends mixed in. every
// accepted byte runs through a local predictor, and each accepted token is
// compared field by field against the oldest expected token. the sender and
// the receiver idle at different rates per phase, the last phase with none.
// ----------------------------------------------------------------------------
module char_stream_token_classifier_tb;
    import cstc_pkg::*;

    localparam int MAX_LEN      = DEFAULT_MAX_TOKEN_LEN;
    localparam int PHASE_ITEMS  = 460;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] FP_NONE = 2'd0;
    localparam logic [1:0] FP_INT  = 2'd1;
    localparam logic [1:0] FP_DOT  = 2'd2;
    localparam logic [1:0] FP_FRAC = 2'd3;

    typedef struct {
        byte_t  b;
        bit     typed;
        int     n;
        token_t t0;
        token_t t1;
    } row_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   byte_valid  = 1'b0;
    logic   byte_stall;
    byte_t  byte_data   = '0;
    logic   token_valid;
    logic   token_stall = 1'b0;
    token_t token_data;

    int src_idle_pct = 17;
    int stall_pct    = 76;
    int items_sent   = 0;
    int fault_count  = 0;

    row_t   rows_in_flight [$];
    token_t expected_tokens [$];
    token_t predicted [$];
    row_t   dir_rows [25];

    // predictor state
    logic [31:0] m_pos;
    logic [31:0] m_start;
    logic [7:0]  m_len;
    logic        m_ovf;
    logic [39:0] m_head;
    logic        m_int_ok;
    logic        m_id_ok;
    logic [1:0]  m_fp;

    string keywords [3] = '{"float", "int", "print"};
    string near_keywords [12] = '{"flo", "floats", "f", "in", "intx", "i", "prin",
                                  "printx", "p", "Float", "pr1nt", "int_"};
    string odd_numbers [8] = '{"1.", "12.", ".5", "1.2.3", "3.x", "0.0", "09.75", "1..2"};
    string punct = "!().,;:*/#$%&?@[]{}~^<>\"'";
    string ops   = "=+-";

    char_stream_token_classifier DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        token_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic token_t mk_tok(input kind_t k, input logic [31:0] s,
                                      input logic [7:0] l, input logic o, input logic last);
        token_t t;
        t.token_kind      = k;
        t.token_start     = s;
        t.token_length    = l;
        t.length_overflow = o;
        t.last_of_run     = last;
        return t;
    endfunction

    function automatic row_t by_model(input logic [7:0] c, input logic e);
        row_t r;
        r.b.ch           = c;
        r.b.end_of_input = e;
        r.typed          = 1'b0;
        r.n              = 0;
        r.t0             = '0;
        r.t1             = '0;
        return r;
    endfunction

    function automatic row_t by_hand(input logic [7:0] c, input logic e, input int n,
                                     input token_t a, input token_t b);
        row_t r;
        r       = by_model(c, e);
        r.typed = 1'b1;
        r.n     = n;
        r.t0    = a;
        r.t1    = b;
        return r;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_digit(c) || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 10)
            return 8'("0" + r);
        else if (r < 36)
            return 8'("a" + r - 10);
        else if (r < 62)
            return 8'("A" + r - 36);
        return "_";
    endfunction

    task automatic clear_token();
        m_start  = '0;
        m_len    = '0;
        m_ovf    = 1'b0;
        m_head   = '0;
        m_int_ok = 1'b1;
        m_id_ok  = 1'b1;
        m_fp     = FP_NONE;
    endtask

    task automatic emit(input kind_t k, input logic [31:0] s, input logic [7:0] l,
                        input logic o);
        predicted.insert(predicted.size(), mk_tok(k, s, l, o, 1'b0));
    endtask

    task automatic flush_token();
        kind_t k;
        if (m_len != 0)
        begin
            k = KIND_NIL;
            if (m_len == 5 && m_head == "float")
                k = KIND_KW_FLT;
            else if (m_len == 3 && m_head[23:0] == "int")
                k = KIND_KW_INT;
            else if (m_len == 5 && m_head == "print")
                k = KIND_PRINT;
            else if (m_int_ok)
                k = KIND_INT;
            else if (m_id_ok)
                k = KIND_ID;
            else if (m_fp == FP_FRAC)
                k = KIND_FLOAT;
            emit(k, m_start, m_len, m_ovf);
            clear_token();
        end
    endtask

    task automatic extend_token(input logic [7:0] c);
        if (m_len == 0)
        begin
            m_start  = m_pos;
            m_int_ok = (c >= "1" && c <= "9");
            m_fp     = is_digit(c) ? FP_INT : FP_NONE;
        end
        else
        begin
            if (!is_digit(c))
                m_int_ok = 1'b0;
            case (m_fp)
                FP_INT:          m_fp = is_digit(c) ? FP_INT : (c == "." ? FP_DOT : FP_NONE);
                FP_DOT, FP_FRAC: m_fp = is_digit(c) ? FP_FRAC : FP_NONE;
                default:         m_fp = FP_NONE;
            endcase
        end
        if (!is_word_char(c))
            m_id_ok = 1'b0;
        if (m_len < 5)
            m_head = {m_head[31:0], c};
        if (m_len == MAX_LEN)
            m_ovf = 1'b1;
        else
            m_len = m_len + 8'd1;
    endtask

    // tokens caused by one byte land in predicted
    task automatic classify_byte(input byte_t b);
        predicted.delete();
        if (b.end_of_input || b.ch == CH_EOF || b.ch == CH_NUL)
        begin
            if (b.end_of_input || b.ch == CH_EOF)
                flush_token();
            emit(KIND_END, m_pos, 8'd0, 1'b0);
            m_pos = '0;
            clear_token();
        end
        else if (b.ch == CH_SPACE || b.ch == CH_LF)
        begin
            flush_token();
            m_pos = m_pos + 1;
        end
        else if (b.ch == CH_EQ || b.ch == CH_PLUS || b.ch == CH_MINUS)
        begin
            flush_token();
            emit(b.ch == CH_EQ ? KIND_ASSIGN : (b.ch == CH_PLUS ? KIND_PLUS : KIND_MINUS),
                 m_pos, 8'd1, 1'b0);
            m_pos = m_pos + 1;
        end
        else
        begin
            extend_token(b.ch);
            m_pos = m_pos + 1;
        end
        if (predicted.size() != 0)
            predicted[predicted.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic check_token(input token_t got);
        token_t exp;
        if (expected_tokens.size() == 0)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("unexpected token: kind %0d start %0d len %0d ovf %0b last %0b",
                         got.token_kind, got.token_start, got.token_length,
                         got.length_overflow, got.last_of_run);
        end
        else
        begin
            exp = expected_tokens.pop_front();
            if (got.token_kind !== exp.token_kind || got.token_start !== exp.token_start ||
                got.token_length !== exp.token_length ||
                got.length_overflow !== exp.length_overflow ||
                got.last_of_run !== exp.last_of_run)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                begin
                    $write("token mismatch: exp kind %0d start %0d len %0d ovf %0b last %0b, ",
                           exp.token_kind, exp.token_start, exp.token_length,
                           exp.length_overflow, exp.last_of_run);
                    $display("got kind %0d start %0d len %0d ovf %0b last %0b",
                             got.token_kind, got.token_start, got.token_length,
                             got.length_overflow, got.last_of_run);
                end
            end
        end
    endtask

    initial
    begin
        m_pos = '0;
        clear_token();
    end

    always @(posedge clk)
    begin : monitor
        row_t r;
        if (rst_n)
        begin
            // byte transaction accepted
            if (byte_valid && !byte_stall)
            begin
                r = rows_in_flight.pop_front();
                classify_byte(r.b);
                if (r.typed)
                begin
                    if (r.n > 0)
                        expected_tokens.insert(expected_tokens.size(), r.t0);
                    if (r.n > 1)
                        expected_tokens.insert(expected_tokens.size(), r.t1);
                end
                else
                begin
                    foreach (predicted[i])
                        expected_tokens.insert(expected_tokens.size(), predicted[i]);
                end
            end
            if (token_valid && !token_stall)
                check_token(token_data);
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input row_t r);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= r.b;
        rows_in_flight.insert(rows_in_flight.size(), r);
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_ch(input logic [7:0] c);
        send_byte(by_model(c, 1'b0));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_ch(s[i]);
    endtask

    task automatic send_end();
        case ($urandom_range(0, 2))
            0:       send_byte(by_model(8'($urandom_range(0, 255)), 1'b1));
            1:       send_ch(CH_EOF);
            default: send_ch(CH_NUL);
        endcase
    endtask

    task automatic send_long_token(input int len);
        bit digits_only;
        digits_only = $urandom_range(0, 1);
        send_ch("1");
        for (int i = 1; i < len; i++)
            send_ch(digits_only ? rand_digit() : rand_word_char());
        send_ch(CH_SPACE);
    endtask

    task automatic send_random_token();
        case ($urandom_range(0, 19))
            0, 1:   send_text(keywords[$urandom_range(0, 2)]);
            2, 3:   send_text(near_keywords[$urandom_range(0, 11)]);
            4, 5:
            begin
                send_ch(8'("0" + $urandom_range(1, 9)));
                repeat ($urandom_range(0, 6)) send_ch(rand_digit());
            end
            6:
            begin
                send_ch("0");
                repeat ($urandom_range(0, 3)) send_ch(rand_digit());
            end
            7, 8, 9:
                repeat ($urandom_range(1, 8)) send_ch(rand_word_char());
            10, 11:
            begin
                repeat ($urandom_range(1, 3)) send_ch(rand_digit());
                send_ch(".");
                repeat ($urandom_range(1, 3)) send_ch(rand_digit());
            end
            12:     send_text(odd_numbers[$urandom_range(0, 7)]);
            13:
            begin
                repeat ($urandom_range(1, 4)) send_ch(punct[$urandom_range(0, punct.len() - 1)]);
                if ($urandom_range(0, 1))
                    send_ch(rand_word_char());
            end
            14, 15: send_ch(ops[$urandom_range(0, 2)]);
            16:     send_ch(8'($urandom_range(0, 255)));
            default:
                repeat ($urandom_range(1, 3)) send_ch($urandom_range(0, 1) ? CH_SPACE : CH_LF);
        endcase
        case ($urandom_range(0, 3))
            0:       ;
            1, 2:    send_ch(CH_SPACE);
            default: send_ch(CH_LF);
        endcase
        if ($urandom_range(0, 39) == 0)
            send_end();
    endtask

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int phase_end;
        dir_rows = '{
            by_hand(CH_NUL, 1'b0, 1, mk_tok(KIND_END, 32'd0, 8'd0, 1'b0, 1'b1), '0),
            by_hand(CH_EOF, 1'b1, 1, mk_tok(KIND_END, 32'd0, 8'd0, 1'b0, 1'b1), '0),
            by_hand(CH_MINUS, 1'b0, 1, mk_tok(KIND_MINUS, 32'd0, 8'd1, 1'b0, 1'b1), '0),
            by_model("f", 1'b0), by_model("l", 1'b0), by_model("o", 1'b0),
            by_model("a", 1'b0), by_model("t", 1'b0), by_model(CH_LF, 1'b0),
            by_model("i", 1'b0), by_model("n", 1'b0), by_model("t", 1'b0),
            by_model(CH_EQ, 1'b0),
            by_model("p", 1'b0), by_model("r", 1'b0), by_model("i", 1'b0),
            by_model("n", 1'b0), by_model("t", 1'b0), by_model(CH_PLUS, 1'b0),
            by_model("3", 1'b0), by_model(".", 1'b0), by_model("5", 1'b0),
            by_model(CH_EOF, 1'b0),
            by_model("Z", 1'b0), by_model(CH_NUL, 1'b0)
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            phase_end = items_sent + PHASE_ITEMS;
            case (phase)
                0:
                begin
                    src_idle_pct = 17;
                    stall_pct    = 76;
                    send_long_token(MAX_LEN);
                end
                1:
                begin
                    src_idle_pct = 76;
                    stall_pct    = 17;
                    send_long_token(MAX_LEN + 1);
                end
                default:
                begin
                    src_idle_pct = 0;
                    stall_pct    = 0;
                    send_long_token($urandom_range(MAX_LEN + 2, MAX_LEN + 45));
                end
            endcase
            while (items_sent < phase_end)
                send_random_token();
        end
        byte_valid <= 1'b0;

        while (expected_tokens.size() != 0 || rows_in_flight.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_tokens.size() != 0)
            fault_count += expected_tokens.size();
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ char_stream_token_classifier.f @@
design/cstc_pkg.sv
design/char_stream_token_classifier.sv
design/cstc_checker.sv
bench/char_stream_token_classifier_tb.sv
